[rtl/plx_pkg.sv]
// ----------------------------------------------------------------------------
// plx_pkg
// Shared types, token classes, character codes and tables for the scanner.
// ----------------------------------------------------------------------------
package plx_pkg;

  typedef enum logic [2:0] {
    M_IDLE,
    M_WORD,
    M_NUM,
    M_COLON,
    M_LESS,
    M_GREATER,
    M_CHARLIT,
    M_STRLIT
  } mode_e;

  typedef struct packed {
    logic [5:0]  cls;
    logic [7:0]  len;
    logic [15:0] line;
    logic [15:0] col;
  } token_t;

  // Tokens completed by one item, in order; cnt is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  localparam logic [5:0] C_IDENT     = 6'd20;
  localparam logic [5:0] C_NUMBER    = 6'd21;
  localparam logic [5:0] C_CHARACTER = 6'd22;
  localparam logic [5:0] C_STRING    = 6'd23;
  localparam logic [5:0] C_ASSIGN    = 6'd24;
  localparam logic [5:0] C_LEQ       = 6'd25;
  localparam logic [5:0] C_NEQ       = 6'd26;
  localparam logic [5:0] C_GEQ       = 6'd27;
  localparam logic [5:0] C_PERIOD    = 6'd28;
  localparam logic [5:0] C_COMMA     = 6'd29;
  localparam logic [5:0] C_SIGQUOTE  = 6'd30;
  localparam logic [5:0] C_LBRACK    = 6'd31;
  localparam logic [5:0] C_RBRACK    = 6'd32;
  localparam logic [5:0] C_LPAREN    = 6'd33;
  localparam logic [5:0] C_RPAREN    = 6'd34;
  localparam logic [5:0] C_COLON     = 6'd35;
  localparam logic [5:0] C_EQUAL     = 6'd36;
  localparam logic [5:0] C_LESS      = 6'd37;
  localparam logic [5:0] C_GREATER   = 6'd38;
  localparam logic [5:0] C_SEMI      = 6'd39;
  localparam logic [5:0] C_DOUQUOTE  = 6'd40;
  localparam logic [5:0] C_PLUS      = 6'd41;
  localparam logic [5:0] C_MINUS     = 6'd42;
  localparam logic [5:0] C_STAR      = 6'd43;
  localparam logic [5:0] C_SLASH     = 6'd44;
  localparam logic [5:0] C_UNKNOWN   = 6'd45;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;

  localparam int NUM_KW = 20;
  localparam int KW_MAX = 9;

  // Padded with spaces; only the first KW_LEN characters are compared.
  localparam logic [8*KW_MAX-1:0] KW_TEXT [NUM_KW] = '{
    "procedure", "function ", "const    ", "var      ", "array    ",
    "of       ", "integer  ", "char     ", "begin    ", "end      ",
    "if       ", "then     ", "else     ", "case     ", "read     ",
    "write    ", "for      ", "downto   ", "to       ", "do       "
  };

  localparam int KW_LEN [NUM_KW] = '{
    9, 8, 5, 3, 5, 2, 7, 4, 5, 3, 2, 4, 4, 4, 4, 5, 3, 6, 2, 2
  };

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= CH_LA) && (b <= CH_LZ)) || ((b >= CH_UA) && (b <= CH_UZ));
  endfunction

  function automatic logic [5:0] symbol_class(input logic [7:0] b);
    logic [5:0] c;
    case (b)
      CH_PERIOD: c = C_PERIOD;
      CH_COMMA:  c = C_COMMA;
      CH_SQUOTE: c = C_SIGQUOTE;
      CH_LBRACK: c = C_LBRACK;
      CH_RBRACK: c = C_RBRACK;
      CH_LPAREN: c = C_LPAREN;
      CH_RPAREN: c = C_RPAREN;
      CH_COLON:  c = C_COLON;
      CH_EQUAL:  c = C_EQUAL;
      CH_LESS:   c = C_LESS;
      CH_GREAT:  c = C_GREATER;
      CH_SEMI:   c = C_SEMI;
      CH_DQUOTE: c = C_DOUQUOTE;
      CH_PLUS:   c = C_PLUS;
      CH_MINUS:  c = C_MINUS;
      CH_STAR:   c = C_STAR;
      CH_SLASH:  c = C_SLASH;
      default:   c = C_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

[rtl/pascal_subset_lexer.sv]
// ----------------------------------------------------------------------------
// pascal_subset_lexer
// Streaming scanner for a small Pascal-like language.
// ----------------------------------------------------------------------------
// Takes one source byte (or an end-of-input flush) per item, one item per
// clock while input ready is high, and returns tokens with class, saturating
// length, start line and start column. The scan state updates in the
// accepting cycle; completed tokens go into a four-entry result queue that
// hands out one token per cycle while the output is ready, so the output
// port sets the sustained rate. Input ready drops while the queue holds
// three or more tokens.
module pascal_subset_lexer
  import plx_pkg::*;
#(
  parameter int KEYWORD_CHARS = 9,
  parameter int MAX_TOKEN_LEN = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  token_class_o,
  output logic [7:0]  token_length_o,
  output logic [15:0] start_line_o,
  output logic [15:0] start_column_o,
  output logic        last_of_run_o
);

  logic   accept;
  push_t  push;
  token_t tok;

  assign accept = in_valid_i && in_ready_o;

  plx_scan #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_scan (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .in_byte_i,
    .end_of_input_i,
    .push_o         (push)
  );

  plx_outq u_outq (
    .clk_i,
    .rst_ni,
    .push_en_i (accept),
    .push_i    (push),
    .room_o    (in_ready_o),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .tok_o     (tok),
    .last_o    (last_of_run_o)
  );

  assign token_class_o  = tok.cls;
  assign token_length_o = tok.len;
  assign start_line_o   = tok.line;
  assign start_column_o = tok.col;

endmodule

[rtl/plx_scan.sv]
// ----------------------------------------------------------------------------
// plx_scan
// Scanner state and single-pass token logic: one byte or flush per item,
// up to two completed tokens handed to the result queue in the same cycle.
// ----------------------------------------------------------------------------
module plx_scan
  import plx_pkg::*;
#(
  parameter int KEYWORD_CHARS = 9,
  parameter int MAX_TOKEN_LEN = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output push_t      push_o
);

  localparam int RLW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int IW  = $clog2(KEYWORD_CHARS);

  mode_e            mode_q, mode_d;
  logic [RLW-1:0]   rl_q, rl_d;
  logic [15:0]      tl_q, tl_d, tc_q, tc_d;
  logic [15:0]      cl_q, cl_d, cc_q, cc_d;
  logic [1:0]       qf_q, qf_d;  // bit0 single-quote open, bit1 double-quote open
  logic [7:0]       wbuf_q [KEYWORD_CHARS];

  logic             buf_we;
  logic [IW-1:0]    buf_idx;

  logic [15:0]      line_n, col_n;
  logic [RLW-1:0]   rl_grow;
  logic [5:0]       word_cls, pend_cls;
  token_t           pend_tok;

  // Outcome of a byte seen with no run in progress
  logic [1:0]       ib_cnt;
  token_t           ib_t0, ib_t1;
  logic             ib_start, ib_wbuf0;
  mode_e            ib_mode;
  logic [1:0]       ib_qf;

  always_comb begin
    line_n = cl_q;
    col_n  = cc_q;
    if (in_byte_i == CH_LF) begin
      if (cl_q != 16'hFFFF) line_n = cl_q + 16'd1;
      col_n = '0;
    end else if (cc_q != 16'hFFFF) begin
      col_n = cc_q + 16'd1;
    end
  end

  assign rl_grow = (rl_q < RLW'(MAX_TOKEN_LEN)) ? rl_q + RLW'(1) : rl_q;

  // Parallel keyword compare; the lowest matching index wins.
  always_comb begin
    logic hit;
    word_cls = C_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      hit = (int'(rl_q) == KW_LEN[k]);
      for (int i = 0; i < KW_MAX; i++) begin
        if ((i < KW_LEN[k]) && (wbuf_q[i] != KW_TEXT[k][8*(KW_MAX-1-i) +: 8])) hit = 1'b0;
      end
      if (hit) word_cls = 6'(k);
    end
  end

  always_comb begin
    case (mode_q)
      M_WORD:    pend_cls = word_cls;
      M_NUM:     pend_cls = C_NUMBER;
      M_COLON:   pend_cls = C_COLON;
      M_LESS:    pend_cls = C_LESS;
      M_GREATER: pend_cls = C_GREATER;
      M_CHARLIT: pend_cls = C_CHARACTER;
      M_STRLIT:  pend_cls = C_STRING;
      default:   pend_cls = C_UNKNOWN;
    endcase
  end

  assign pend_tok = '{cls: pend_cls, len: 8'(rl_q), line: tl_q, col: tc_q};

  always_comb begin
    logic single;
    logic [7:0] qch;
    single   = qf_q[0];
    qch      = single ? CH_SQUOTE : CH_DQUOTE;
    ib_cnt   = 2'd0;
    ib_t0    = '0;
    ib_t1    = '0;
    ib_start = 1'b0;
    ib_wbuf0 = 1'b0;
    ib_mode  = M_IDLE;
    ib_qf    = qf_q;
    if (qf_q != 2'b00) begin
      if (is_blank(in_byte_i)) begin
        ib_cnt = 2'd0;
      end else if (in_byte_i == qch) begin
        // empty literal, then the closing quote
        ib_cnt = 2'd2;
        ib_t0  = '{cls: single ? C_CHARACTER : C_STRING, len: 8'd0, line: line_n, col: col_n};
        ib_t1  = '{cls: single ? C_SIGQUOTE : C_DOUQUOTE, len: 8'd1, line: line_n, col: col_n};
        ib_qf  = 2'b00;
      end else begin
        ib_start = 1'b1;
        ib_mode  = single ? M_CHARLIT : M_STRLIT;
      end
    end else if (is_blank(in_byte_i)) begin
      ib_cnt = 2'd0;
    end else if (is_letter(in_byte_i)) begin
      ib_start = 1'b1;
      ib_mode  = M_WORD;
      ib_wbuf0 = 1'b1;
    end else if (is_digit(in_byte_i)) begin
      ib_start = 1'b1;
      ib_mode  = M_NUM;
    end else if (in_byte_i == CH_COLON) begin
      ib_start = 1'b1;
      ib_mode  = M_COLON;
    end else if (in_byte_i == CH_LESS) begin
      ib_start = 1'b1;
      ib_mode  = M_LESS;
    end else if (in_byte_i == CH_GREAT) begin
      ib_start = 1'b1;
      ib_mode  = M_GREATER;
    end else begin
      ib_cnt = 2'd1;
      ib_t0  = '{cls: symbol_class(in_byte_i), len: 8'd1, line: line_n, col: col_n};
      if (in_byte_i == CH_SQUOTE) ib_qf = 2'b01;
      else if (in_byte_i == CH_DQUOTE) ib_qf = 2'b10;
    end
  end

  always_comb begin
    logic use_idle;
    logic [5:0] op_cls;
    logic lit_single;
    use_idle   = 1'b0;
    op_cls     = C_UNKNOWN;
    lit_single = (mode_q == M_CHARLIT);
    mode_d     = mode_q;
    rl_d       = rl_q;
    tl_d       = tl_q;
    tc_d       = tc_q;
    cl_d       = cl_q;
    cc_d       = cc_q;
    qf_d       = qf_q;
    buf_we     = 1'b0;
    buf_idx    = '0;
    push_o     = '0;

    if (end_of_input_i) begin
      if (mode_q != M_IDLE) begin
        push_o.cnt  = 2'd1;
        push_o.tok0 = pend_tok;
      end
      mode_d = M_IDLE;
      qf_d   = 2'b00;
    end else begin
      cl_d = line_n;
      cc_d = col_n;
      case (mode_q)
        M_WORD: begin
          if (is_letter(in_byte_i) || is_digit(in_byte_i)) begin
            if (int'(rl_q) < KEYWORD_CHARS) begin
              buf_we  = 1'b1;
              buf_idx = rl_q[IW-1:0];
            end
            rl_d = rl_grow;
          end else begin
            use_idle = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(in_byte_i)) rl_d = rl_grow;
          else use_idle = 1'b1;
        end
        M_COLON, M_LESS, M_GREATER: begin
          if (in_byte_i == CH_EQUAL) begin
            op_cls = (mode_q == M_COLON) ? C_ASSIGN : (mode_q == M_LESS) ? C_LEQ : C_GEQ;
          end else if ((in_byte_i == CH_GREAT) && (mode_q == M_LESS)) begin
            op_cls = C_NEQ;
          end
          if (op_cls != C_UNKNOWN) begin
            mode_d      = M_IDLE;
            push_o.cnt  = 2'd1;
            push_o.tok0 = '{cls: op_cls, len: 8'd2, line: tl_q, col: tc_q};
          end else begin
            use_idle = 1'b1;
          end
        end
        M_CHARLIT, M_STRLIT: begin
          if (in_byte_i == (lit_single ? CH_SQUOTE : CH_DQUOTE)) begin
            mode_d      = M_IDLE;
            qf_d        = 2'b00;
            push_o.cnt  = 2'd2;
            push_o.tok0 = pend_tok;
            push_o.tok1 = '{cls: lit_single ? C_SIGQUOTE : C_DOUQUOTE, len: 8'd1,
                            line: line_n, col: col_n};
          end else begin
            rl_d = rl_grow;
          end
        end
        default: begin
          push_o.cnt  = ib_cnt;
          push_o.tok0 = ib_t0;
          push_o.tok1 = ib_t1;
        end
      endcase

      // A run ended by this byte goes first, then whatever the byte gives.
      if (use_idle) begin
        mode_d      = M_IDLE;
        push_o.cnt  = 2'd1 + ib_cnt;
        push_o.tok0 = pend_tok;
        push_o.tok1 = ib_t0;
      end

      if ((mode_q == M_IDLE) || use_idle) begin
        qf_d = ib_qf;
        if (ib_start) begin
          mode_d = ib_mode;
          rl_d   = RLW'(1);
          tl_d   = line_n;
          tc_d   = col_n;
        end
        if (ib_wbuf0) begin
          buf_we  = 1'b1;
          buf_idx = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      rl_q   <= '0;
      tl_q   <= 16'd1;
      tc_q   <= '0;
      cl_q   <= 16'd1;
      cc_q   <= '0;
      qf_q   <= 2'b00;
    end else if (accept_i) begin
      mode_q <= mode_d;
      rl_q   <= rl_d;
      tl_q   <= tl_d;
      tc_q   <= tc_d;
      cl_q   <= cl_d;
      cc_q   <= cc_d;
      qf_q   <= qf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && buf_we) wbuf_q[buf_idx] <= in_byte_i;
  end

endmodule

[rtl/plx_outq.sv]
// ----------------------------------------------------------------------------
// plx_outq
// Four-entry result queue: takes up to two tokens per cycle, pops one when ready.
// ----------------------------------------------------------------------------
module plx_outq
  import plx_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_en_i,
  input  push_t  push_i,
  output logic   room_o,
  output logic   valid_o,
  input  logic   ready_i,
  output token_t tok_o,
  output logic   last_o
);

  token_t     mem_q  [4];
  logic       last_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] n_push;
  logic       pop;

  assign n_push  = push_en_i ? push_i.cnt : 2'd0;
  assign valid_o = (cnt_q != 3'd0);
  assign pop     = valid_o && ready_i;
  assign room_o  = (cnt_q <= 3'd2);  // space for the two tokens an item may give
  assign tok_o   = mem_q[rd_q];
  assign last_o  = last_q[rd_q];
  assign cnt_d   = cnt_q + 3'(n_push) - 3'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push;
      rd_q  <= rd_q + 2'(pop);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q]  <= push_i.tok0;
      last_q[wr_q] <= (n_push == 2'd1);
    end
    if (n_push == 2'd2) begin
      mem_q[wr_q + 2'd1]  <= push_i.tok1;
      last_q[wr_q + 2'd1] <= 1'b1;
    end
  end

endmodule

[rtl/plx_checker.sv]
// ----------------------------------------------------------------------------
// plx_checker
// Port-level checks on the scanner's token stream, bound to the top level.
// ----------------------------------------------------------------------------
module plx_checker
  import plx_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [5:0]  token_class_o,
  input logic [7:0]  token_length_o,
  input logic [15:0] start_line_o,
  input logic [15:0] start_column_o,
  input logic        last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_class_o)
      && $stable(token_length_o) && $stable(start_line_o)
      && $stable(start_column_o) && $stable(last_of_run_o))
    else $error("result item changed while stalled");

  a_line_from_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> start_line_o != 16'd0)
    else $error("token start line is zero");

  a_pair_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_class_o >= C_ASSIGN) && (token_class_o <= C_GEQ)
      |-> token_length_o == 8'd2)
    else $error("two-character operator with wrong length");

  a_single_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_class_o >= C_PERIOD) |-> token_length_o == 8'd1
      && token_class_o <= C_UNKNOWN)
    else $error("symbol or unknown token with bad class or length");

  a_kw_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_class_o < C_IDENT)
      |-> (token_length_o >= 8'd2) && (token_length_o <= 8'(KW_MAX)))
    else $error("keyword token with impossible length");

endmodule

bind pascal_subset_lexer plx_checker u_plx_checker (.*);

[sim/pascal_subset_lexer_test.sv]
// ----------------------------------------------------------------------------
// pascal_subset_lexer_test
// Self-checking bench for the streaming Pascal-subset scanner. A short
// directed byte stream and a long stream of random token fragments are fed
// through a valid/ready driver with random gaps. Every accepted item runs
// through a scanner model in the bench, and each token that comes out is
// checked field by field against the oldest predicted token.
// ----------------------------------------------------------------------------
module pascal_subset_lexer_test;
  import plx_pkg::*;

  localparam int KEYWORD_CHARS = 9;
  localparam int MAX_TOKEN_LEN = 255;
  localparam int MAX_POS       = 65535;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 32;
  localparam int TOTAL_ITEMS   = 750;

  localparam logic [7:0] SYMBOL_CHARS [17] = '{
    CH_PERIOD, CH_COMMA, CH_SQUOTE, CH_LBRACK, CH_RBRACK, CH_LPAREN, CH_RPAREN,
    CH_COLON, CH_EQUAL, CH_LESS, CH_GREAT, CH_SEMI, CH_DQUOTE, CH_PLUS,
    CH_MINUS, CH_STAR, CH_SLASH
  };

  string reserved_words [20] = '{
    "procedure", "function", "const", "var", "array", "of", "integer",
    "char", "begin", "end", "if", "then", "else", "case", "read", "write",
    "for", "downto", "to", "do"
  };

  typedef struct {
    logic [7:0] data;
    logic       flush;
  } source_item_t;

  typedef struct {
    logic [5:0]  cls;
    logic [7:0]  len;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } lex_token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_input = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [5:0]  token_class;
  logic [7:0]  token_length;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic        last_of_run;

  source_item_t pending_items[$];
  lex_token_t   expected_tokens[$];
  lex_token_t   item_tokens[$];

  int   error_count = 0;
  int   items_sent = 0;
  int   stall_cycles = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic in_taken = 1'b0;
  logic calm_phase;

  // scanner model state
  mode_e      scan_state = M_IDLE;
  logic [7:0] word_buf [KEYWORD_CHARS];
  int         run_len = 0;
  int         tok_line = 1;
  int         tok_col = 0;
  int         cur_line = 1;
  int         cur_col = 0;
  logic       sq_open = 1'b0;
  logic       dq_open = 1'b0;

  pascal_subset_lexer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .in_byte_i      (in_byte),
    .end_of_input_i (end_of_input),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .token_class_o  (token_class),
    .token_length_o (token_length),
    .start_line_o   (start_line),
    .start_column_o (start_column),
    .last_of_run_o  (last_of_run)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic blank_char(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

  function automatic logic letter_char(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic digit_char(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [5:0] single_symbol(input logic [7:0] b);
    for (int i = 0; i < 17; i++) begin
      if (SYMBOL_CHARS[i] == b) return 6'(C_PERIOD + i);
    end
    return C_UNKNOWN;
  endfunction

  function automatic logic [5:0] word_kind();
    logic same;
    for (int k = 0; k < 20; k++) begin
      if (reserved_words[k].len() == run_len && run_len <= KEYWORD_CHARS) begin
        same = 1'b1;
        for (int i = 0; i < run_len; i++) begin
          if (word_buf[i] != reserved_words[k][i]) same = 1'b0;
        end
        if (same) return 6'(k);
      end
    end
    return C_IDENT;
  endfunction

  function automatic void put_token(input logic [5:0] c, input int len, input int line,
                                    input int col);
    lex_token_t t;
    t.cls  = c;
    t.len  = len[7:0];
    t.line = line[15:0];
    t.col  = col[15:0];
    t.last = 1'b0;
    item_tokens.push_back(t);
  endfunction

  function automatic void open_run(input mode_e m);
    scan_state = m;
    run_len    = 1;
    tok_line   = cur_line;
    tok_col    = cur_col;
  endfunction

  function automatic void grow_run();
    if (run_len < MAX_TOKEN_LEN) run_len++;
  endfunction

  function automatic void flush_pending();
    logic [5:0] c;
    case (scan_state)
      M_WORD:    c = word_kind();
      M_NUM:     c = C_NUMBER;
      M_COLON:   c = C_COLON;
      M_LESS:    c = C_LESS;
      M_GREATER: c = C_GREATER;
      M_CHARLIT: c = C_CHARACTER;
      M_STRLIT:  c = C_STRING;
      default:   return;
    endcase
    scan_state = M_IDLE;
    put_token(c, run_len, tok_line, tok_col);
  endfunction

  // Byte seen with no token in progress, possibly just after an opening quote.
  function automatic void start_from_idle(input logic [7:0] b);
    logic single;
    if (sq_open || dq_open) begin
      single = sq_open;
      if (blank_char(b)) return;
      if (b == (single ? CH_SQUOTE : CH_DQUOTE)) begin
        // empty literal, then the closing quote itself
        put_token(single ? C_CHARACTER : C_STRING, 0, cur_line, cur_col);
        put_token(single ? C_SIGQUOTE : C_DOUQUOTE, 1, cur_line, cur_col);
        sq_open = 1'b0;
        dq_open = 1'b0;
        return;
      end
      open_run(single ? M_CHARLIT : M_STRLIT);
      return;
    end
    if (blank_char(b)) return;
    if (letter_char(b)) begin
      open_run(M_WORD);
      word_buf[0] = b;
      return;
    end
    if (digit_char(b)) begin
      open_run(M_NUM);
      return;
    end
    if (b == CH_COLON) begin
      open_run(M_COLON);
      return;
    end
    if (b == CH_LESS) begin
      open_run(M_LESS);
      return;
    end
    if (b == CH_GREAT) begin
      open_run(M_GREATER);
      return;
    end
    if (b == CH_SQUOTE) sq_open = 1'b1;
    else if (b == CH_DQUOTE) dq_open = 1'b1;
    put_token(single_symbol(b), 1, cur_line, cur_col);
  endfunction

  function automatic void scan_item(input logic [7:0] b, input logic flush);
    logic [5:0] pair;
    logic [5:0] close_cls;
    logic [7:0] quote;
    item_tokens.delete();
    if (flush) begin
      flush_pending();
      scan_state = M_IDLE;
      sq_open = 1'b0;
      dq_open = 1'b0;
    end else begin
      if (b == CH_LF) begin
        if (cur_line < MAX_POS) cur_line++;
        cur_col = 0;
      end else if (cur_col < MAX_POS) begin
        cur_col++;
      end
      case (scan_state)
        M_WORD: begin
          if (letter_char(b) || digit_char(b)) begin
            if (run_len < KEYWORD_CHARS) word_buf[run_len] = b;
            grow_run();
          end else begin
            flush_pending();
            start_from_idle(b);
          end
        end
        M_NUM: begin
          if (digit_char(b)) begin
            grow_run();
          end else begin
            flush_pending();
            start_from_idle(b);
          end
        end
        M_COLON, M_LESS, M_GREATER: begin
          pair = C_UNKNOWN;
          if (b == CH_EQUAL) begin
            pair = (scan_state == M_COLON) ? C_ASSIGN :
                   (scan_state == M_LESS) ? C_LEQ : C_GEQ;
          end else if (b == CH_GREAT && scan_state == M_LESS) begin
            pair = C_NEQ;
          end
          if (pair != C_UNKNOWN) begin
            scan_state = M_IDLE;
            put_token(pair, 2, tok_line, tok_col);
          end else begin
            flush_pending();
            start_from_idle(b);
          end
        end
        M_CHARLIT, M_STRLIT: begin
          quote     = (scan_state == M_CHARLIT) ? CH_SQUOTE : CH_DQUOTE;
          close_cls = (scan_state == M_CHARLIT) ? C_SIGQUOTE : C_DOUQUOTE;
          if (b == quote) begin
            flush_pending();
            sq_open = 1'b0;
            dq_open = 1'b0;
            put_token(close_cls, 1, cur_line, cur_col);
          end else begin
            grow_run();
          end
        end
        default: start_from_idle(b);
      endcase
    end
    if (item_tokens.size() > 0) item_tokens[item_tokens.size() - 1].last = 1'b1;
    foreach (item_tokens[i]) expected_tokens.push_back(item_tokens[i]);
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic void push_byte(input logic [7:0] b);
    source_item_t it;
    it.data  = b;
    it.flush = 1'b0;
    pending_items.push_back(it);
  endfunction

  function automatic void push_flush();
    source_item_t it;
    it.data  = 8'($urandom_range(255));
    it.flush = 1'b1;
    pending_items.push_back(it);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] random_letter();
    logic [7:0] b;
    b = 8'("a" + $urandom_range(25));
    if ($urandom_range(3) == 0) b = b - 8'h20;
    return b;
  endfunction

  function automatic logic [7:0] random_alnum();
    if ($urandom_range(3) == 0) return 8'("0" + $urandom_range(9));
    return random_letter();
  endfunction

  function automatic logic [7:0] random_unknown();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (blank_char(b) || letter_char(b) || digit_char(b) ||
               single_symbol(b) != C_UNKNOWN);
    return b;
  endfunction

  function automatic void add_fragment();
    int         kind;
    int         n;
    int         sep;
    logic [7:0] b;
    logic [7:0] quote;
    string      s;
    kind = $urandom_range(99);
    if (kind < 18) begin
      push_text(reserved_words[$urandom_range(19)]);
    end else if (kind < 28) begin
      push_byte(random_letter());
      n = $urandom_range(10);
      repeat (n) push_byte(random_alnum());
    end else if (kind < 30) begin
      // keyword with extra text or in upper case stays an identifier
      s = reserved_words[$urandom_range(19)];
      if ($urandom_range(1)) push_text(s.toupper());
      else begin
        push_text(s);
        push_byte(random_alnum());
      end
    end else if (kind < 40) begin
      n = $urandom_range(1, 6);
      repeat (n) push_byte(8'("0" + $urandom_range(9)));
    end else if (kind < 50) begin
      case ($urandom_range(3))
        0: push_text(":=");
        1: push_text("<=");
        2: push_text("<>");
        default: push_text(">=");
      endcase
    end else if (kind < 55) begin
      case ($urandom_range(2))
        0: push_byte(CH_COLON);
        1: push_byte(CH_LESS);
        default: push_byte(CH_GREAT);
      endcase
    end else if (kind < 67) begin
      do begin
        b = SYMBOL_CHARS[$urandom_range(16)];
      end while (b == CH_SQUOTE || b == CH_DQUOTE);
      push_byte(b);
    end else if (kind < 79) begin
      quote = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
      push_byte(quote);
      if ($urandom_range(2) == 0) push_byte(CH_SPACE);
      n = $urandom_range(8);
      repeat (n) begin
        if ($urandom_range(4) == 0) begin
          do b = 8'($urandom_range(255)); while (b == quote);
        end else begin
          b = $urandom_range(5) == 0 ? CH_SPACE : random_alnum();
        end
        push_byte(b);
      end
      if ($urandom_range(6) == 0) push_flush();
      else push_byte(quote);
    end else if (kind < 85) begin
      push_byte(random_unknown());
    end else if (kind < 90) begin
      push_flush();
    end else if (kind < 95) begin
      push_byte(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) push_byte(CH_LF);
    end
    sep = $urandom_range(99);
    if (sep < 50) push_byte(CH_SPACE);
    else if (sep < 60) push_byte(CH_LF);
    else if (sep < 65) push_byte(CH_TAB);
    else if (sep < 70) push_byte(CH_CR);
  endfunction

  // ---------------- test sequence ----------------

  initial begin
    // directed: keyword, upper case word, operators, empty and blank-ended
    // literals, byte extremes, flushes with and without a pending token
    push_text("do END1:=42 '' \"x \"<><=>=");
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(CH_TAB);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(CH_COLON);
    push_flush();
    push_flush();

    // one run long enough to saturate the length
    push_byte(random_letter());
    repeat (MAX_TOKEN_LEN + 2) push_byte(random_alnum());
    push_byte(CH_SPACE);
    while (pending_items.size() < TOTAL_ITEMS) add_fragment();
    push_flush();

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid || expected_tokens.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // no idling on either side for a stretch in the middle of the run
  assign calm_phase = (items_sent >= 400) && (items_sent < 550);

  always @(negedge clk_i) begin : drive_input
    source_item_t next_item;
    if (rst_ni && (!in_valid || in_taken)) begin
      if (pending_items.size() > 0 && (calm_phase || $urandom_range(99) >= 28)) begin
        next_item = pending_items.pop_front();
        in_valid     <= 1'b1;
        in_byte      <= next_item.data;
        end_of_input <= next_item.flush;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long hold-off once, so the result queue fills and input ready drops
  always @(negedge clk_i) begin : drive_output
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && items_sent >= 200) begin
      hold_done = 1'b1;
      hold_left = 80;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm_phase || ($urandom_range(99) >= 28);
    end
  end

  always @(posedge clk_i) begin : check_tokens
    lex_token_t want;
    in_taken <= in_valid && in_ready;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        scan_item(in_byte, end_of_input);
        items_sent++;
      end
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          flag_error($sformatf("token class %0d line %0d col %0d with none expected",
                               token_class, start_line, start_column));
        end else begin
          want = expected_tokens.pop_front();
          if (token_class !== want.cls)
            flag_error($sformatf("class %0d, want %0d", token_class, want.cls));
          if (token_length !== want.len)
            flag_error($sformatf("length %0d, want %0d", token_length, want.len));
          if (start_line !== want.line)
            flag_error($sformatf("line %0d, want %0d", start_line, want.line));
          if (start_column !== want.col)
            flag_error($sformatf("column %0d, want %0d", start_column, want.col));
          if (last_of_run !== want.last)
            flag_error($sformatf("last flag %0b, want %0b", last_of_run, want.last));
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ERROR: no item moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
